[hw/rtl/stsp_pkg.sv]
// Shared types and constants for the scope trace plotter.
package stsp_pkg;

   localparam int CHANNELS   = 2;
   localparam int FILT_WORDS = 6;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int SAMPLE_W   = 16;
   localparam int WORD_W     = 32;
   localparam int DVD_W      = 24;

   localparam logic [DIM_W-1:0] DIM_MAX         = 13'd4096;
   localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd320;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd200;
   localparam logic [DIM_W-1:0] SAMPLES_RESET   = 13'd1024;
   localparam logic [1:0]       STYLE_RESET     = 2'd0;
   localparam int               STYLE_LINE_BIT  = 0;
   localparam int               STYLE_COLOR_BIT = 1;
   localparam logic [1:0]       TRACE_PLAIN     = 2'd1;
   localparam logic [1:0]       TRACE_COLOR     = 2'd3;

   typedef enum logic [1:0] {
      CSR_DRAW_STYLE        = 2'd0,
      CSR_FRAME_WIDTH       = 2'd1,
      CSR_FRAME_HEIGHT      = 2'd2,
      CSR_SAMPLES_PER_FRAME = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                       channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic [COORD_W-1:0]         sample_index;
   } req_word_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_pos;
      logic [COORD_W-1:0] y_first;
      logic [COORD_W-1:0] y_second;
      logic [COORD_W-1:0] y_third;
      logic [1:0]         trace_count;
      logic               segment_valid;
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y_first;
      logic [COORD_W-1:0] prev_y_second;
      logic [COORD_W-1:0] prev_y_third;
   } rsp_word_type;

   typedef struct packed {
      logic [DIM_W-1:0]   depth;
      logic [COORD_W-1:0] offset;
      logic [COORD_W-1:0] top;
   } geo_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] y2;
      logic [COORD_W-1:0] y3;
   } point_type;

   typedef struct packed {
      logic                       start;
      logic                       color;
      logic                       channel;
      logic signed [SAMPLE_W-1:0] sample;
   } filt_cmd_type;

   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] index;
      logic [DIM_W-1:0]   span;
      logic [DIM_W-1:0]   count;
      logic [COORD_W-1:0] limit;
   } xdiv_cmd_type;

endpackage

[hw/rtl/stsp_xdiv.sv]
// Restoring divider for the horizontal plot coordinate.
module stsp_xdiv
   import stsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  xdiv_cmd_type       cmd,
   output logic               done,
   output logic [COORD_W-1:0] x_pos
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   typedef enum logic [1:0] {
      D_IDLE,
      D_STEP,
      D_FIN
   } div_state_type;

   div_state_type      state_ff, state_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DVD_W-1:0]   quo_ff, quo_in;
   logic [DIM_W-1:0]   rem_ff, rem_in;
   logic [DIM_W-1:0]   div_ff, div_in;
   logic [COORD_W-1:0] lim_ff, lim_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [DIM_W:0]     trial;
   logic [DIM_W:0]     diff;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      lim_in   = lim_ff;
      x_in     = x_ff;
      case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               quo_in   = DVD_W'(cmd.index) * DVD_W'(cmd.span);
               rem_in   = '0;
               div_in   = cmd.count;
               lim_in   = cmd.limit;
               cnt_in   = CNT_W'(DVD_W);
               done_in  = 1'b0;
               state_in = D_STEP;
            end
         end
         D_STEP: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = diff[DIM_W-1:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIM_W-1:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (quo_ff > DVD_W'(lim_ff)) begin
               x_in = lim_ff;
            end else begin
               x_in = quo_ff[COORD_W-1:0];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      lim_ff <= lim_in;
      x_ff   <= x_in;
   end

   assign done  = done_ff;
   assign x_pos = x_ff;

endmodule

[hw/rtl/stsp_filt.sv]
// Filter sequencer: state-variable filter cascade over the filter store (colour style), y scaling.
module stsp_filt
   import stsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  filt_cmd_type       cmd,
   input  geo_type            geo,
   output logic               done,
   output logic [COORD_W-1:0] y_first,
   output logic [COORD_W-1:0] y_second,
   output logic [COORD_W-1:0] y_third
);

   localparam int DEPTH   = CHANNELS * FILT_WORDS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ACC_W   = 35;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int FULL_W  = MUL_A_W + MUL_B_W;
   localparam int PROD_W  = 48;
   localparam int RAW_W   = 30;

   localparam logic [ADDR_W-1:0] OFS_L1 = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] OFS_B1 = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] OFS_H1 = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] OFS_L2 = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] OFS_B2 = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] OFS_H2 = ADDR_W'(5);

   localparam logic signed [MUL_B_W-1:0] COEF1 = 18'sd9830;
   localparam logic signed [MUL_B_W-1:0] COEF2 = 18'sd29491;
   localparam logic [PROD_W-1:0]         ROUND_HALF = 48'd32768;

   typedef enum logic [4:0] {
      F_IDLE, F_RD0, F_RD1, F_RD3, F_RD4, F_H1,
      F_MB1, F_RB1, F_AB1, F_ML1, F_RL1, F_AL1,
      F_H2A, F_H2B, F_H2,
      F_MB2, F_RB2, F_AB2, F_ML2, F_RL2, F_AL2,
      F_MY1, F_FY1, F_FY2, F_FY3,
      F_MRAW, F_FRAW
   } filt_state_type;

   function automatic logic signed [ACC_W-1:0] ext_word(input logic signed [WORD_W-1:0] w);
      return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      if (&v[ACC_W-1:WORD_W-1] || ~|v[ACC_W-1:WORD_W-1]) begin
         return v[WORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [MUL_A_W-1:0] mul_word(input logic signed [WORD_W-1:0] w);
      return {w[WORD_W-1], w};
   endfunction

   function automatic logic [COORD_W-1:0] scale_y(input logic [PROD_W-1:0] p,
                                                  input geo_type g);
      logic signed [PROD_W-1:0] num;
      logic [PROD_W-25:0]       q;
      num = $signed({{(PROD_W-COORD_W-24){1'b0}}, g.offset, 24'b0}) + $signed(p);
      q   = num[PROD_W-1:24];
      if (num[PROD_W-1]) begin
         return '0;
      end else if (q > (PROD_W-24)'(g.top)) begin
         return g.top;
      end else begin
         return q[COORD_W-1:0];
      end
   endfunction

   filt_state_type            state_ff, state_in;
   logic                      done_ff, done_in;
   logic [ADDR_W-1:0]         base_ff, base_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   geo_type                   geo_ff, geo_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]         prod_ff;
   logic signed [WORD_W-1:0]  cm_ff, cm_in;
   logic signed [WORD_W-1:0]  l1_ff, l1_in, b1_ff, b1_in, h1_ff, h1_in;
   logic signed [WORD_W-1:0]  l2_ff, l2_in, b2_ff, b2_in, h2_ff, h2_in;
   logic [COORD_W-1:0]        y1_ff, y1_in, y2_ff, y2_in, y3_ff, y3_in;
   logic [DEPTH-1:0]          valid_ff, valid_in;

   logic signed [WORD_W-1:0]  filter_store [DEPTH];
   logic signed [WORD_W-1:0]  rdata_ff;
   logic                      rvld_ff;
   logic signed [WORD_W-1:0]  rword;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [WORD_W-1:0]  wr_data;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [FULL_W-1:0]  prod_full;
   logic [PROD_W-1:0]         rnd_sum;
   logic signed [RAW_W-1:0]   raw_num;
   logic signed [MUL_B_W-1:0] depth_b;

   assign rword     = rvld_ff ? rdata_ff : '0;
   assign prod_full = mul_a * mul_b;
   assign rnd_sum   = prod_ff + ROUND_HALF;
   assign depth_b   = $signed({{(MUL_B_W-DIM_W){1'b0}}, geo_ff.depth});
   assign raw_num   = $signed({{(RAW_W-COORD_W-16){1'b0}}, geo_ff.offset, 16'b0})
                    + $signed(prod_ff[RAW_W-1:0]);

   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      base_in   = base_ff;
      sample_in = sample_ff;
      geo_in    = geo_ff;
      acc_in    = acc_ff;
      cm_in     = rnd_sum[PROD_W-1:16];
      l1_in     = l1_ff;
      b1_in     = b1_ff;
      h1_in     = h1_ff;
      l2_in     = l2_ff;
      b2_in     = b2_ff;
      h2_in     = h2_ff;
      y1_in     = y1_ff;
      y2_in     = y2_ff;
      y3_in     = y3_ff;
      rd_addr   = base_ff;
      wr_en     = 1'b0;
      wr_addr   = base_ff;
      wr_data   = '0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         F_IDLE: begin
            if (cmd.start) begin
               base_in   = ADDR_W'(cmd.channel) * ADDR_W'(FILT_WORDS);
               sample_in = cmd.sample;
               geo_in    = geo;
               done_in   = 1'b0;
               state_in  = cmd.color ? F_RD0 : F_MRAW;
            end
         end
         F_RD0: begin
            rd_addr  = base_ff + OFS_L1;
            acc_in   = {{(ACC_W-SAMPLE_W-8){sample_ff[SAMPLE_W-1]}}, sample_ff, 8'b0};
            state_in = F_RD1;
         end
         F_RD1: begin
            rd_addr  = base_ff + OFS_B1;
            l1_in    = rword;
            acc_in   = acc_ff - ext_word(rword);
            state_in = F_RD3;
         end
         F_RD3: begin
            rd_addr  = base_ff + OFS_L2;
            b1_in    = rword;
            acc_in   = acc_ff - (ext_word(rword) <<< 1);
            state_in = F_RD4;
         end
         F_RD4: begin
            rd_addr  = base_ff + OFS_B2;
            l2_in    = rword;
            state_in = F_H1;
         end
         F_H1: begin
            b2_in    = rword;
            h1_in    = sat_word(acc_ff);
            wr_en    = 1'b1;
            wr_addr  = base_ff + OFS_H1;
            wr_data  = sat_word(acc_ff);
            state_in = F_MB1;
         end
         F_MB1: begin
            mul_a    = mul_word(h1_ff);
            mul_b    = COEF1;
            state_in = F_RB1;
         end
         F_RB1: begin
            state_in = F_AB1;
         end
         F_AB1: begin
            b1_in    = sat_word(ext_word(b1_ff) + ext_word(cm_ff));
            wr_en    = 1'b1;
            wr_addr  = base_ff + OFS_B1;
            wr_data  = sat_word(ext_word(b1_ff) + ext_word(cm_ff));
            state_in = F_ML1;
         end
         F_ML1: begin
            mul_a    = mul_word(b1_ff);
            mul_b    = COEF1;
            state_in = F_RL1;
         end
         F_RL1: begin
            state_in = F_AL1;
         end
         F_AL1: begin
            l1_in    = sat_word(ext_word(l1_ff) + ext_word(cm_ff));
            wr_en    = 1'b1;
            wr_addr  = base_ff + OFS_L1;
            wr_data  = sat_word(ext_word(l1_ff) + ext_word(cm_ff));
            acc_in   = ext_word(b1_ff) + ext_word(h1_ff);
            state_in = F_H2A;
         end
         F_H2A: begin
            acc_in   = acc_ff - (ext_word(b2_ff) <<< 1);
            state_in = F_H2B;
         end
         F_H2B: begin
            acc_in   = acc_ff - ext_word(l2_ff);
            state_in = F_H2;
         end
         F_H2: begin
            h2_in    = sat_word(acc_ff);
            wr_en    = 1'b1;
            wr_addr  = base_ff + OFS_H2;
            wr_data  = sat_word(acc_ff);
            state_in = F_MB2;
         end
         F_MB2: begin
            mul_a    = mul_word(h2_ff);
            mul_b    = COEF2;
            state_in = F_RB2;
         end
         F_RB2: begin
            state_in = F_AB2;
         end
         F_AB2: begin
            b2_in    = sat_word(ext_word(b2_ff) + ext_word(cm_ff));
            wr_en    = 1'b1;
            wr_addr  = base_ff + OFS_B2;
            wr_data  = sat_word(ext_word(b2_ff) + ext_word(cm_ff));
            state_in = F_ML2;
         end
         F_ML2: begin
            mul_a    = mul_word(b2_ff);
            mul_b    = COEF2;
            state_in = F_RL2;
         end
         F_RL2: begin
            state_in = F_AL2;
         end
         F_AL2: begin
            l2_in    = sat_word(ext_word(l2_ff) + ext_word(cm_ff));
            wr_en    = 1'b1;
            wr_addr  = base_ff + OFS_L2;
            wr_data  = sat_word(ext_word(l2_ff) + ext_word(cm_ff));
            acc_in   = ext_word(b2_ff) + ext_word(h2_ff);
            state_in = F_MY1;
         end
         F_MY1: begin
            mul_a    = mul_word(l1_ff);
            mul_b    = depth_b;
            state_in = F_FY1;
         end
         F_FY1: begin
            y1_in    = scale_y(prod_ff, geo_ff);
            mul_a    = mul_word(l2_ff);
            mul_b    = depth_b;
            state_in = F_FY2;
         end
         F_FY2: begin
            y2_in    = scale_y(prod_ff, geo_ff);
            mul_a    = acc_ff[MUL_A_W-1:0];
            mul_b    = depth_b;
            state_in = F_FY3;
         end
         F_FY3: begin
            y3_in    = scale_y(prod_ff, geo_ff);
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         F_MRAW: begin
            mul_a    = {{(MUL_A_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
            mul_b    = depth_b;
            state_in = F_FRAW;
         end
         F_FRAW: begin
            y1_in    = raw_num[RAW_W-1] ? '0 : raw_num[COORD_W+15:16];
            y2_in    = '0;
            y3_in    = '0;
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
      base_ff   <= base_in;
      sample_ff <= sample_in;
      geo_ff    <= geo_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_full[PROD_W-1:0];
      cm_ff     <= cm_in;
      l1_ff     <= l1_in;
      b1_ff     <= b1_in;
      h1_ff     <= h1_in;
      l2_ff     <= l2_in;
      b2_ff     <= b2_in;
      h2_ff     <= h2_in;
      y1_ff     <= y1_in;
      y2_ff     <= y2_in;
      y3_ff     <= y3_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         filter_store[wr_addr] <= wr_data;
      end
      rdata_ff <= filter_store[rd_addr];
      rvld_ff  <= valid_ff[rd_addr];
   end

   assign done     = done_ff;
   assign y_first  = y1_ff;
   assign y_second = y2_ff;
   assign y_third  = y3_ff;

endmodule

[hw/rtl/scope_trace_svf_plotter.sv]
// Top level of the scope trace plotter: registers, control, point store, output stage.
//
//   channel | direction | signals                          | word
//   --------+-----------+----------------------------------+---------------------------
//   req     | in        | req_valid / req_ready / req_word | channel, sample, index
//   rsp     | out       | rsp_valid / rsp_ready / rsp_word | x, three y, segment start
//   csr     | in        | csr_valid / csr_ready            | csr_index, csr_data
//
// One sample word at a time: the result is registered once both compute units are done, and
// the next input word is taken once that result is loaded; the 24-step x divider is the longer
// unit in every style (the colour filter sequence finishes within it).
// Reset clears the registers to their defaults and marks both stores empty; no sweep.
// A result waiting on rsp_ready does not stop the next input word; a second finished
// result holds in the compute units until the output register frees.
module scope_trace_svf_plotter
   import stsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_word_type     rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   localparam int LP_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUSY,
      T_HOLD
   } top_state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lo);
      if (v < lo) begin
         return lo;
      end else if (v > DIM_MAX) begin
         return DIM_MAX;
      end else begin
         return v;
      end
   endfunction

   top_state_type       state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic [1:0]          style_ff, style_in;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [DIM_W-1:0]    count_ff, count_in;
   logic [LP_ADDR_W-1:0] ch_ff, ch_in;
   logic                seg_ff, seg_in;
   logic                color_ff, color_in;
   logic [CHANNELS-1:0] lp_valid_ff, lp_valid_in;

   point_type           last_point [CHANNELS];
   point_type           lp_rdata_ff;
   logic                lp_rvld_ff;
   point_type           prev;
   point_type           cur;

   logic                line;
   logic                color;
   logic [DIM_W-1:0]    w;
   logic [DIM_W-1:0]    w_m1;
   logic [DIM_W-1:0]    h;
   logic [DIM_W-1:0]    h_m2;
   logic [DIM_W-1:0]    d;
   geo_type             geo;
   logic                accept;
   logic                start;
   logic                out_free;
   logic                load;
   filt_cmd_type        filt_cmd;
   xdiv_cmd_type        xdiv_cmd;
   logic                filt_done;
   logic                xdiv_done;
   logic [COORD_W-1:0]  x_val;
   logic [COORD_W-1:0]  y1_val;
   logic [COORD_W-1:0]  y2_val;
   logic [COORD_W-1:0]  y3_val;

   assign line   = style_ff[STYLE_LINE_BIT];
   assign color  = style_ff[STYLE_COLOR_BIT];
   assign w      = clamp_dim(width_ff, 13'd1);
   assign w_m1   = w - 13'd1;
   assign h      = clamp_dim(height_ff, 13'd2);
   assign h_m2   = h - 13'd2;
   assign d      = line ? h - 13'd1 : h;

   assign geo.depth  = d;
   assign geo.offset = d[DIM_W-1:1];
   assign geo.top    = h_m2[COORD_W-1:0];

   assign req_ready = (state_ff == T_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (int'(req_word.channel) < CHANNELS);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign filt_cmd.start   = start;
   assign filt_cmd.color   = color;
   assign filt_cmd.channel = req_word.channel;
   assign filt_cmd.sample  = req_word.sample;

   assign xdiv_cmd.start = start;
   assign xdiv_cmd.index = req_word.sample_index;
   assign xdiv_cmd.span  = line ? w_m1 : w;
   assign xdiv_cmd.count = clamp_dim(count_ff, 13'd1);
   assign xdiv_cmd.limit = w_m1[COORD_W-1:0];

   stsp_xdiv u_xdiv (
      .clock (clock),
      .reset (reset),
      .cmd   (xdiv_cmd),
      .done  (xdiv_done),
      .x_pos (x_val)
   );

   stsp_filt u_filt (
      .clock    (clock),
      .reset    (reset),
      .cmd      (filt_cmd),
      .geo      (geo),
      .done     (filt_done),
      .y_first  (y1_val),
      .y_second (y2_val),
      .y_third  (y3_val)
   );

   assign prev   = lp_rvld_ff ? lp_rdata_ff : '0;
   assign cur.x  = x_val;
   assign cur.y1 = y1_val;
   assign cur.y2 = y2_val;
   assign cur.y3 = y3_val;

   always_comb begin
      state_in     = state_ff;
      style_in     = style_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      count_in     = count_ff;
      ch_in        = ch_ff;
      seg_in       = seg_ff;
      color_in     = color_ff;
      load         = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DRAW_STYLE:        style_in  = csr_data[1:0];
            CSR_FRAME_WIDTH:       width_in  = csr_data;
            CSR_FRAME_HEIGHT:      height_in = csr_data;
            CSR_SAMPLES_PER_FRAME: count_in  = csr_data;
            default: ;
         endcase
      end
      case (state_ff)
         T_IDLE: begin
            if (start) begin
               ch_in    = LP_ADDR_W'(req_word.channel);
               seg_in   = line && (req_word.sample_index != '0);
               color_in = color;
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (xdiv_done && filt_done) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = T_IDLE;
               end else begin
                  state_in = T_HOLD;
               end
            end
         end
         T_HOLD: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      lp_valid_in  = lp_valid_ff;
      if (load) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.x_pos         = cur.x;
         rsp_word_in.y_first       = cur.y1;
         rsp_word_in.y_second      = cur.y2;
         rsp_word_in.y_third       = cur.y3;
         rsp_word_in.trace_count   = color_ff ? TRACE_COLOR : TRACE_PLAIN;
         rsp_word_in.segment_valid = seg_ff;
         rsp_word_in.prev_x        = seg_ff ? prev.x : '0;
         rsp_word_in.prev_y_first  = seg_ff ? prev.y1 : '0;
         rsp_word_in.prev_y_second = (seg_ff && color_ff) ? prev.y2 : '0;
         rsp_word_in.prev_y_third  = (seg_ff && color_ff) ? prev.y3 : '0;
         lp_valid_in[ch_ff]        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         style_ff     <= STYLE_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         count_ff     <= SAMPLES_RESET;
         lp_valid_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         style_ff     <= style_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         count_ff     <= count_in;
         lp_valid_ff  <= lp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      ch_ff       <= ch_in;
      seg_ff      <= seg_in;
      color_ff    <= color_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         last_point[ch_ff] <= cur;
      end
      if (start) begin
         lp_rdata_ff <= last_point[LP_ADDR_W'(req_word.channel)];
         lp_rvld_ff  <= lp_valid_ff[LP_ADDR_W'(req_word.channel)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
